FILE: rtl/dhd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhd_pkg
// Shared types and constants for the detection head decode block.
// ----------------------------------------------------------------------------
package dhd_pkg;

  localparam int SCORE_W = 16;
  localparam int COORD_W = 16;
  localparam int PAD_W   = 12;
  localparam int CLASS_W = 7;
  localparam int OUT_W   = 20;
  localparam int NUM_W   = 20;   // signed corner numerator, Q.5
  localparam int MAG_W   = 18;   // magnitude of a numerator
  localparam int DVD_W   = 31;   // mag * 4096 + scale
  localparam int DIV_W   = 17;   // 2 * scale
  localparam int BIT_W   = 5;    // divider bit counter

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_PAD_X     = 2'd1;
  localparam logic [1:0] CFG_PAD_Y     = 2'd2;
  localparam logic [1:0] CFG_SCALE     = 2'd3;

  localparam logic [1:0] CORNER_LEFT   = 2'd0;
  localparam logic [1:0] CORNER_BOTTOM = 2'd3;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(DVD_W - 1);

  localparam logic [OUT_W-1:0] OUT_MAX = 20'h7FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 20'h80000;

  typedef struct packed {
    logic       take;     // input beat accepted
    logic       load;     // load dividend for corner
    logic       step;     // one quotient bit
    logic       save;     // store saturated corner
    logic       present;  // move box to output register
    logic [1:0] corner;
  } dhd_cmd_t;

  typedef struct packed {
    logic emit;      // last class beat passes threshold
    logic out_free;  // output register can take a box
  } dhd_stat_t;

endpackage

FILE: rtl/detection_head_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_head_decode
// Per-anchor class argmax and letterbox box decode to source pixels.
// ----------------------------------------------------------------------------
// Class score beats are taken one per clock while no box is being decoded.
// A beat that ends an anchor and whose best score beats the threshold starts
// the box decode: four corner divisions by the resize scale run one after
// another on one shared radix-2 divider, each a load, 31 quotient bits and a
// save. Input then stalls while the divisions run and the box is handed to
// the output register, plus any wait for the previous box to leave it.
// Anchors below threshold leave the sequencer idle and produce nothing.
module detection_head_decode import dhd_pkg::*; #(
  parameter int CLASS_COUNT = 80
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SCORE_W-1:0]      in_class_score,
  input  logic [COORD_W-1:0]      in_center_x,
  input  logic [COORD_W-1:0]      in_center_y,
  input  logic [COORD_W-1:0]      in_box_width,
  input  logic [COORD_W-1:0]      in_box_height,
  input  logic                    in_last_class,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_left_x,
  output logic signed [OUT_W-1:0] out_top_y,
  output logic signed [OUT_W-1:0] out_right_x,
  output logic signed [OUT_W-1:0] out_bottom_y,
  output logic [SCORE_W-1:0]      out_best_score,
  output logic [CLASS_W-1:0]      out_best_class
);

  dhd_cmd_t  cmd;
  dhd_stat_t stat;

  dhd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dhd_datapath #(.CLASS_COUNT(CLASS_COUNT)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_class_score (in_class_score),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_box_width   (in_box_width),
    .in_box_height  (in_box_height),
    .in_last_class  (in_last_class),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_x     (out_left_x),
    .out_top_y      (out_top_y),
    .out_right_x    (out_right_x),
    .out_bottom_y   (out_bottom_y),
    .out_best_score (out_best_score),
    .out_best_class (out_best_class)
  );

endmodule

FILE: rtl/dhd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhd_ctrl
// Sequencer: accepts class beats, runs four shared divisions per box.
// ----------------------------------------------------------------------------
module dhd_ctrl import dhd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dhd_stat_t stat,
  output dhd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_SAVE = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       corner_r, corner_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;

  always_comb begin
    state_nxt   = state_r;
    corner_nxt  = corner_r;
    bit_nxt     = bit_r;
    cmd         = '0;
    cmd.corner  = corner_r;
    in_stall    = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && stat.emit) begin
          state_nxt  = S_LOAD;
          corner_nxt = CORNER_LEFT;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        bit_nxt   = LAST_BIT;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_SAVE;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      S_SAVE: begin
        cmd.save = 1'b1;
        if (corner_r == CORNER_BOTTOM) begin
          state_nxt = S_HOLD;
        end else begin
          corner_nxt = corner_r + 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      S_HOLD: begin
        // wait for the previous box to drain
        if (stat.out_free) begin
          cmd.present = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      corner_r <= '0;
      bit_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
      bit_r    <= bit_nxt;
    end
  end

endmodule

FILE: rtl/dhd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhd_datapath
// Running max, corner numerators, radix-2 divider and output register.
// ----------------------------------------------------------------------------
module dhd_datapath import dhd_pkg::*; #(
  parameter int CLASS_COUNT = 80
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic [SCORE_W-1:0]        in_class_score,
  input  logic [COORD_W-1:0]        in_center_x,
  input  logic [COORD_W-1:0]        in_center_y,
  input  logic [COORD_W-1:0]        in_box_width,
  input  logic [COORD_W-1:0]        in_box_height,
  input  logic                      in_last_class,
  input  dhd_cmd_t                  cmd,
  output dhd_stat_t                 stat,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   out_left_x,
  output logic signed [OUT_W-1:0]   out_top_y,
  output logic signed [OUT_W-1:0]   out_right_x,
  output logic signed [OUT_W-1:0]   out_bottom_y,
  output logic [SCORE_W-1:0]        out_best_score,
  output logic [CLASS_W-1:0]        out_best_class
);

  localparam logic [CLASS_W-1:0] CNT_MAX = CLASS_W'(CLASS_COUNT - 1);

  logic [SCORE_W-1:0] thr_r;
  logic [PAD_W-1:0]   pad_x_r, pad_y_r;
  logic [15:0]        scale_r;

  logic [SCORE_W-1:0] max_r, max_nxt;
  logic [CLASS_W-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic [SCORE_W-1:0] box_score_r;
  logic [CLASS_W-1:0] box_class_r;

  logic signed [NUM_W-1:0] num_r [4];
  logic signed [NUM_W-1:0] num_nxt [4];
  logic [OUT_W-1:0]        res_r [4];

  logic [DVD_W-1:0] dvd_r, quo_r;
  logic [DIV_W-1:0] rem_r;
  logic             neg_r;

  logic              out_valid_r;
  logic [OUT_W-1:0]  o_l_r, o_t_r, o_r_r, o_b_r;
  logic [SCORE_W-1:0] o_score_r;
  logic [CLASS_W-1:0] o_class_r;

  // running strict-greater maximum
  logic upd;
  assign upd     = in_class_score > max_r;
  assign max_nxt = upd ? in_class_score : max_r;
  assign idx_nxt = upd ? cnt_r : idx_r;
  assign cnt_nxt = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  assign stat.emit     = in_last_class && (max_nxt > thr_r);
  assign stat.out_free = !out_valid_r || !out_stall;

  // corner numerators in Q.5
  logic signed [NUM_W-1:0] cx2, cy2, w_e, h_e, px_e, py_e;
  assign cx2  = $signed({3'b0, in_center_x, 1'b0});
  assign cy2  = $signed({3'b0, in_center_y, 1'b0});
  assign w_e  = $signed({4'b0, in_box_width});
  assign h_e  = $signed({4'b0, in_box_height});
  assign px_e = $signed({3'b0, pad_x_r, 5'b0});
  assign py_e = $signed({3'b0, pad_y_r, 5'b0});
  assign num_nxt[0] = cx2 - w_e - px_e;
  assign num_nxt[1] = cy2 - h_e - py_e;
  assign num_nxt[2] = cx2 + w_e - px_e;
  assign num_nxt[3] = cy2 + h_e - py_e;

  // divider operands
  logic [15:0]      s_eff;
  logic [DIV_W-1:0] divisor;
  logic signed [NUM_W-1:0] num_sel;
  logic [NUM_W-1:0] mag_full;
  logic [DVD_W-1:0] dvd_load;
  assign s_eff    = (scale_r == '0) ? 16'd1 : scale_r;
  assign divisor  = {s_eff, 1'b0};
  assign num_sel  = num_r[cmd.corner];
  assign mag_full = num_sel[NUM_W-1] ? NUM_W'(-num_sel) : NUM_W'(num_sel);
  assign dvd_load = {1'b0, mag_full[MAG_W-1:0], 12'b0} + DVD_W'(s_eff);

  logic [DIV_W:0] trial;
  logic           ge;
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  // round-half-away quotient, saturated
  logic [OUT_W-1:0] sat;
  always_comb begin
    if (neg_r) begin
      sat = (quo_r > DVD_W'(524288)) ? OUT_MIN : OUT_W'(-quo_r);
    end else begin
      sat = (quo_r > DVD_W'(OUT_MAX)) ? OUT_MAX : quo_r[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= 16'd16384;
      pad_x_r <= '0;
      pad_y_r <= '0;
      scale_r <= 16'd4096;
      max_r   <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_r   <= cfg_data;
          CFG_PAD_X:     pad_x_r <= cfg_data[PAD_W-1:0];
          CFG_PAD_Y:     pad_y_r <= cfg_data[PAD_W-1:0];
          CFG_SCALE:     scale_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take) begin
        if (in_last_class) begin
          max_r <= '0;
          idx_r <= '0;
          cnt_r <= '0;
        end else begin
          max_r <= max_nxt;
          idx_r <= idx_nxt;
          cnt_r <= cnt_nxt;
        end
      end
      if (cmd.present) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && stat.emit) begin
      for (int i = 0; i < 4; i++) begin
        num_r[i] <= num_nxt[i];
      end
      box_score_r <= max_nxt;
      box_class_r <= idx_nxt;
    end
    if (cmd.load) begin
      dvd_r <= dvd_load;
      quo_r <= '0;
      rem_r <= '0;
      neg_r <= num_sel[NUM_W-1];
    end else if (cmd.step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
    end
    if (cmd.save) begin
      res_r[cmd.corner] <= sat;
    end
    if (cmd.present) begin
      o_l_r     <= res_r[0];
      o_t_r     <= res_r[1];
      o_r_r     <= res_r[2];
      o_b_r     <= res_r[3];
      o_score_r <= box_score_r;
      o_class_r <= box_class_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_x     = $signed(o_l_r);
  assign out_top_y      = $signed(o_t_r);
  assign out_right_x    = $signed(o_r_r);
  assign out_bottom_y   = $signed(o_b_r);
  assign out_best_score = o_score_r;
  assign out_best_class = o_class_r;

endmodule
